// File: sv/rrw_pkg.sv
// Package for the receive reorder window: sizes, command codes, item types and result kinds.
package rrw_pkg;

   localparam int DEPTH       = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int HANDLE_BITS = 16;
   localparam int MAX_OUT     = 32;
   localparam int WIN_W       = 6;
   localparam int WIN_CAP     = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;
   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(20);

   localparam logic CMD_DATA    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [1:0] KIND_DELIVER = 2'd0;
   localparam logic [1:0] KIND_DROP    = 2'd1;
   localparam logic [1:0] KIND_FREE    = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic [31:0] seq_id;
      logic [15:0] buf_handle;
      logic [15:0] payload_length;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [15:0] out_handle;
      logic [31:0] out_seq;
      logic [15:0] out_length;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [15:0]            length;
   } slot_type;

endpackage

// File: sv/receive_reorder_window.sv
// Receive reorder window: a slot memory indexed by sequence id, an in-order walker and a restart sweep.
//
// Issue an item with start while busy is low. A data item that lies outside
// the window (last received id, plus window_size capped at the slot count],
// or whose id is already held, comes back in the next cycle as a dropped
// result and the block stays ready. An accepted data item is written to the
// slot memory; the block then walks forward from the last received id, one
// slot per cycle, reading each held item from the memory through a registered
// read port and delivering it; busy stays high throughout the walk. A restart
// sweeps the slots in ascending id order, one per cycle, freeing every held
// item. Results appear for exactly one cycle on rsp_item with rsp_strobe
// high; the receiver must take them then. The window register may be written
// while busy is low.
module receive_reorder_window (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  rrw_pkg::req_item_type      req_item,
   output logic                       rsp_strobe,
   output rrw_pkg::rsp_item_type      rsp_item,
   input  logic                       csr_wr_en,
   input  logic [rrw_pkg::WIN_W-1:0]  csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_DELIVER = 3'b010,
      ST_FREE    = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic [31:0]                       last_ff, last_in;
   logic [31:0]                       restart_ff, restart_in;
   logic [rrw_pkg::WIN_W-1:0]         window_ff, window_in;
   logic [rrw_pkg::DEPTH-1:0]         valid_ff, valid_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [1:0]                        pend_kind_ff, pend_kind_in;
   logic [31:0]                       pend_seq_ff, pend_seq_in;
   logic                              pend_last_ff, pend_last_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   rrw_pkg::rsp_item_type             rsp_ff, rsp_in;

   rrw_pkg::slot_type                 mem [rrw_pkg::DEPTH];
   rrw_pkg::slot_type                 rd_data_ff;
   rrw_pkg::slot_type                 wr_data;
   logic                              mem_we;

   logic                              accept;
   logic [31:0]                       cur_seq;
   logic [rrw_pkg::IDX_W-1:0]         cur_idx;
   logic [rrw_pkg::IDX_W-1:0]         nxt_idx;
   logic [rrw_pkg::IDX_W-1:0]         req_idx;
   logic [rrw_pkg::WIN_W-1:0]         win_eff;
   logic [31:0]                       top;
   logic                              drop;
   logic [rrw_pkg::DEPTH-1:0]         valid_rest;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   assign cur_seq = last_ff + 32'd1;
   assign cur_idx = cur_seq[rrw_pkg::IDX_W-1:0];
   assign nxt_idx = cur_idx + rrw_pkg::IDX_W'(1);
   assign req_idx = req_item.seq_id[rrw_pkg::IDX_W-1:0];
   assign win_eff = (window_ff > rrw_pkg::WIN_W'(rrw_pkg::WIN_CAP))
                    ? rrw_pkg::WIN_W'(rrw_pkg::WIN_CAP) : window_ff;
   assign top     = last_ff + 32'(win_eff);
   assign drop    = (req_item.seq_id <= last_ff) || (req_item.seq_id > top)
                    || valid_ff[req_idx];

   assign wr_data.handle = req_item.buf_handle[rrw_pkg::HANDLE_BITS-1:0];
   assign wr_data.length = req_item.payload_length;

   always_comb begin
      valid_rest          = valid_ff;
      valid_rest[cur_idx] = 1'b0;
   end

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      restart_in    = restart_ff;
      window_in     = window_ff;
      valid_in      = valid_ff;
      pend_valid_in = 1'b0;
      pend_kind_in  = pend_kind_ff;
      pend_seq_in   = pend_seq_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;

      if (csr_wr_en) begin
         window_in = csr_wr_data;
      end

      // read data for the slot issued last cycle is here now
      if (pend_valid_ff) begin
         rsp_valid_in      = 1'b1;
         rsp_in.out_kind   = pend_kind_ff;
         rsp_in.out_handle = 16'(rd_data_ff.handle);
         rsp_in.out_seq    = pend_seq_ff;
         rsp_in.out_length = rd_data_ff.length;
         rsp_in.last       = pend_last_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.cmd == rrw_pkg::CMD_RESTART) begin
                  restart_in = req_item.seq_id;
                  state_in   = ST_FREE;
               end else if (drop) begin
                  rsp_valid_in      = 1'b1;
                  rsp_in.out_kind   = rrw_pkg::KIND_DROP;
                  rsp_in.out_handle = 16'(wr_data.handle);
                  rsp_in.out_seq    = req_item.seq_id;
                  rsp_in.out_length = req_item.payload_length;
                  rsp_in.last       = 1'b1;
               end else begin
                  mem_we            = 1'b1;
                  valid_in[req_idx] = 1'b1;
                  state_in          = ST_DELIVER;
               end
            end
         end
         ST_DELIVER: begin
            if (valid_ff[cur_idx]) begin
               valid_in[cur_idx] = 1'b0;
               last_in           = cur_seq;
               pend_valid_in     = 1'b1;
               pend_kind_in      = rrw_pkg::KIND_DELIVER;
               pend_seq_in       = cur_seq;
               pend_last_in      = !valid_ff[nxt_idx];
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FREE: begin
            if (valid_ff == '0) begin
               last_in  = restart_ff;
               state_in = ST_IDLE;
            end else begin
               last_in           = cur_seq;
               valid_in[cur_idx] = 1'b0;
               if (valid_ff[cur_idx]) begin
                  pend_valid_in = 1'b1;
                  pend_kind_in  = rrw_pkg::KIND_FREE;
                  pend_seq_in   = cur_seq;
                  pend_last_in  = (valid_rest == '0);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_ff       <= '0;
         window_ff     <= rrw_pkg::WIN_RESET;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         window_ff     <= window_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      restart_ff   <= restart_in;
      pend_kind_ff <= pend_kind_in;
      pend_seq_ff  <= pend_seq_in;
      pend_last_ff <= pend_last_in;
      rsp_ff       <= rsp_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[req_idx] <= wr_data;
      end
      rd_data_ff <= mem[cur_idx];
   end

   a_no_write_under_read: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !$past(mem_we))
      else $error("slot write overlapped a pending read");

   a_drop_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.out_kind == rrw_pkg::KIND_DROP) |-> rsp_item.last)
      else $error("dropped item not marked last");

   a_free_clears_all: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FREE && state_in == ST_IDLE) |=> (valid_ff == '0))
      else $error("restart left slots held");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !pend_valid_ff)
      else $error("read pending while idle");

endmodule

// File: sim/rrw_checker.sv
// Checker for the receive reorder window: predicts every result item and compares it on arrival.
module rrw_checker
   import rrw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_item_type     req_item,
   input  logic             rsp_strobe,
   input  rsp_item_type     rsp_item,
   input  logic             csr_wr_en,
   input  logic [WIN_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending
);

   logic [31:0]      last_rcv;
   logic [DEPTH-1:0] held;
   slot_type         slots [DEPTH];
   logic [WIN_W-1:0] window;
   rsp_item_type     expected_q [$];
   int               errors = 0;

   function automatic rsp_item_type make_rsp(logic [1:0] kind, logic [15:0] handle,
                                             logic [31:0] seq, logic [15:0] len);
      rsp_item_type r;
      r.out_kind   = kind;
      r.out_handle = handle;
      r.out_seq    = seq;
      r.out_length = len;
      r.last       = 1'b0;
      return r;
   endfunction

   task automatic predict_item(input req_item_type it);
      logic [31:0]      sid;
      logic [31:0]      top;
      logic [IDX_W-1:0] s;
      rsp_item_type     r;
      int               n;
      n = 0;
      if (it.cmd == CMD_RESTART) begin
         // free held items in ascending id order
         for (int k = 1; k <= DEPTH; k++) begin
            sid = last_rcv + 32'(k);
            s   = sid[IDX_W-1:0];
            if (held[s] && n < MAX_OUT) begin
               expected_q.push_back(make_rsp(KIND_FREE, 16'(slots[s].handle), sid,
                                             slots[s].length));
               n++;
            end
            held[s] = 1'b0;
         end
         last_rcv = it.seq_id;
      end else begin
         top = last_rcv + 32'((window > WIN_CAP) ? WIN_CAP : int'(window));
         s   = it.seq_id[IDX_W-1:0];
         if (it.seq_id <= last_rcv || it.seq_id > top || held[s]) begin
            expected_q.push_back(make_rsp(KIND_DROP, 16'(it.buf_handle[HANDLE_BITS-1:0]),
                                          it.seq_id, it.payload_length));
            n = 1;
         end else begin
            held[s]         = 1'b1;
            slots[s].handle = it.buf_handle[HANDLE_BITS-1:0];
            slots[s].length = it.payload_length;
            sid = last_rcv + 32'd1;
            while (n < MAX_OUT && held[sid[IDX_W-1:0]]) begin
               s = sid[IDX_W-1:0];
               expected_q.push_back(make_rsp(KIND_DELIVER, 16'(slots[s].handle), sid,
                                             slots[s].length));
               n++;
               held[s]  = 1'b0;
               last_rcv = sid;
               sid      = sid + 32'd1;
            end
         end
      end
      if (n > 0) begin
         r = expected_q.pop_back();
         r.last = 1'b1;
         expected_q.push_back(r);
      end
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected item: out_kind %0d out_seq %0h", got.out_kind, got.out_seq);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      if (got.out_kind !== want.out_kind) begin
         $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
         errors++;
      end
      if (got.out_handle !== want.out_handle) begin
         $error("out_handle: expected %0h, got %0h", want.out_handle, got.out_handle);
         errors++;
      end
      if (got.out_seq !== want.out_seq) begin
         $error("out_seq: expected %0h, got %0h", want.out_seq, got.out_seq);
         errors++;
      end
      if (got.out_length !== want.out_length) begin
         $error("out_length: expected %0h, got %0h", want.out_length, got.out_length);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, got %0d", want.last, got.last);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         last_rcv = '0;
         held     = '0;
         window   = WIN_RESET;
         expected_q.delete();
      end else begin
         if (rsp_strobe) check_result(rsp_item);
         if (csr_wr_en) window = csr_wr_data;
         if (start && !busy) predict_item(req_item);
      end
      fail_count <= errors;
      pending    <= expected_q.size();
   end

endmodule

// File: sim/tb_receive_reorder_window.sv
// Testbench top for the receive reorder window: stimulus, window settings, watchdog and verdict.
module tb_receive_reorder_window;
   import rrw_pkg::*;

   localparam int IDLE_LIMIT = 400;
   localparam int SETTLE     = 40;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   req_item_type     req_item    = '0;
   logic             csr_wr_en   = 1'b0;
   logic [WIN_W-1:0] csr_wr_data = '0;
   logic             busy;
   logic             rsp_strobe;
   rsp_item_type     rsp_item;

   int               fail_count;
   int               pending;
   int               idle_cycles = 0;
   int               burst_left  = 0;
   int               items_sent  = 0;
   logic [WIN_W-1:0] win_now     = WIN_RESET;

   receive_reorder_window dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rrw_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_wr_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_item_type pkt(logic cmd, logic [31:0] id, logic [15:0] handle,
                                        logic [15:0] len);
      req_item_type it;
      it.cmd            = cmd;
      it.seq_id         = id;
      it.buf_handle     = handle;
      it.payload_length = len;
      return it;
   endfunction

   // sender works in bursts; a long burst now and then gives stretches without gaps
   task automatic issue(input req_item_type it);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
      burst_left--;
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic data_item(input logic [31:0] id);
      issue(pkt(CMD_DATA, id, 16'($urandom), 16'($urandom)));
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_window(input logic [WIN_W-1:0] w);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      win_now = w;
   endtask

   // restart at a random base, then runs of in-window ids, shuffled or descending, plus noise
   task automatic run_phase(input int budget, input bit full_first);
      logic [31:0] base;
      logic [31:0] tmp;
      logic [31:0] id;
      logic [31:0] ids [$];
      int          n;
      int          j;
      int          chunks;
      int          w_eff;
      int          stop_at;
      bit          complete;
      bit          full;
      w_eff   = (win_now > WIN_CAP) ? WIN_CAP : int'(win_now);
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 5))
            0:       base = '0;
            1:       base = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
            default: base = $urandom;
         endcase
         issue(pkt(CMD_RESTART, base, 16'($urandom), 16'($urandom)));
         chunks = $urandom_range(1, 3);
         for (int c = 0; c < chunks; c++) begin
            full = full_first && w_eff > 0;
            full_first = 1'b0;
            if (full) begin
               n = w_eff;
            end else begin
               n = (w_eff == 0) ? 3 : $urandom_range(1, (w_eff < 6) ? w_eff : 6);
            end
            ids.delete();
            if (full) begin
               // descending, so the whole window is released by the last item
               for (int k = n; k >= 1; k--) ids.push_back(base + 32'(k));
            end else begin
               for (int k = 1; k <= n; k++) ids.push_back(base + 32'(k));
               for (int k = n - 1; k > 0; k--) begin
                  j      = $urandom_range(0, k);
                  tmp    = ids[k];
                  ids[k] = ids[j];
                  ids[j] = tmp;
               end
            end
            complete = full || ($urandom_range(0, 3) != 0);
            if (!complete) ids.delete($urandom_range(0, n - 1));
            foreach (ids[i]) begin
               if ($urandom_range(0, 7) == 0) begin
                  case ($urandom_range(0, 2))
                     0:       id = (i > 0) ? ids[i-1] : base;
                     1:       id = base + 32'(w_eff) + 32'($urandom_range(1, 8));
                     default: id = $urandom;
                  endcase
                  data_item(id);
               end
               data_item(ids[i]);
            end
            if (!complete) break;
            base = base + 32'(n);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      issue(pkt(CMD_DATA, 32'd0, 16'hFFFF, 16'h0000));
      issue(pkt(CMD_DATA, 32'd1, 16'h0000, 16'hFFFF));
      data_item(32'd3);
      data_item(32'd4);
      data_item(32'd3);
      data_item(32'd2);
      data_item(32'd24);
      data_item(32'd25);
      data_item(32'hFFFF_FFFF);
      issue(pkt(CMD_RESTART, 32'd100, 16'h0000, 16'h0000));
      issue(pkt(CMD_RESTART, 32'd100, 16'hFFFF, 16'hFFFF));
      issue(pkt(CMD_RESTART, 32'hFFFF_FFF0, 16'h1234, 16'h5678));
      data_item(32'hFFFF_FFF1);
      data_item(32'd2);
      issue(pkt(CMD_RESTART, 32'hFFFF_FFFF, 16'hAAAA, 16'h5555));
      data_item(32'd0);
      issue(pkt(CMD_RESTART, 32'd0, 16'h5555, 16'hAAAA));
      data_item(32'd5);
      data_item(32'd7);
      issue(pkt(CMD_RESTART, 32'h1234_5678, 16'h0F0F, 16'hF0F0));
      issue(pkt(CMD_DATA, 32'h1234_5679, 16'hFFFF, 16'hFFFF));

      set_window(6'd63);
      run_phase(36, 1'b1);
      set_window(6'd1);
      run_phase(6, 1'b0);
      set_window(6'd0);
      run_phase(4, 1'b0);
      set_window(6'd33);
      run_phase(6, 1'b0);
      set_window(6'd32);
      run_phase(8, 1'b0);
      set_window(WIN_W'($urandom_range(2, 31)));
      run_phase(8, 1'b0);
      set_window(WIN_RESET);
      run_phase(8, 1'b0);
      drain();

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: receive_reorder_window.f
sv/rrw_pkg.sv
sv/receive_reorder_window.sv
sim/rrw_checker.sv
sim/tb_receive_reorder_window.sv
